// ----- rtl/fcp_pkg.sv -----
// shared types, constants and helpers for the frustum corner and plane block
`timescale 1ns / 1ps
package fcp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int REG_W = 31;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_W = 288;
  localparam int OUT_W = 136;
  localparam int USER_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_NEAR_DIST = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FAR_DIST  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NEAR_HW   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_NEAR_HH   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FAR_HW    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FAR_HH    = 3'd5;

  localparam logic [REG_W-1:0] RST_NEAR_DIST = 31'd65536;
  localparam logic [REG_W-1:0] RST_FAR_DIST  = 31'd6553600;
  localparam logic [REG_W-1:0] RST_NEAR_HW   = 31'd65536;
  localparam logic [REG_W-1:0] RST_NEAR_HH   = 31'd65536;
  localparam logic [REG_W-1:0] RST_FAR_HW    = 31'd6553600;
  localparam logic [REG_W-1:0] RST_FAR_HH    = 31'd6553600;

  localparam logic KIND_CORNER = 1'b0;
  localparam logic KIND_PLANE  = 1'b1;

  localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t [2:0] pos;
    q_t [2:0] dir;
    q_t [2:0] up;
    q_t [2:0] right;
  } job_t;

  typedef struct packed {
    logic [REG_W-1:0] near_dist;
    logic [REG_W-1:0] far_dist;
    logic [REG_W-1:0] near_hw;
    logic [REG_W-1:0] near_hh;
    logic [REG_W-1:0] far_hw;
    logic [REG_W-1:0] far_hh;
  } cfg_t;

  function automatic q_t sat32(input logic signed [71:0] v);
    if (v > SAT_HI) begin
      return 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

endpackage

// ----- rtl/fcp_front.sv -----
// front end: takes a pose and forms the right vector with one shared multiplier
`timescale 1ns / 1ps
module fcp_front import fcp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_data,
  output logic            q_valid,
  input  logic            q_ready,
  output job_t            q_job
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] st;
  logic [2:0] cnt;
  logic [2:0] tag;
  job_t job;
  q_t fa, fb;
  logic signed [63:0] prod, prod_sh, half;
  logic accept;

  assign in_ready = (st == F_IDLE) || (st == F_PUSH && q_ready);
  assign accept = in_valid && in_ready;
  assign q_valid = (st == F_PUSH);
  assign q_job = job;
  assign tag = cnt - 3'd1;
  assign prod_sh = prod >>> FRAC_BITS;

  always_comb begin
    fa = '0;
    fb = '0;
    case (cnt)
      3'd0: begin fa = job.dir[1]; fb = job.up[2]; end
      3'd1: begin fa = job.dir[2]; fb = job.up[1]; end
      3'd2: begin fa = job.dir[2]; fb = job.up[0]; end
      3'd3: begin fa = job.dir[0]; fb = job.up[2]; end
      3'd4: begin fa = job.dir[0]; fb = job.up[1]; end
      3'd5: begin fa = job.dir[1]; fb = job.up[0]; end
      default: begin fa = '0; fb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'($signed(fa)) * 64'($signed(fb));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
      cnt <= '0;
    end else begin
      if (accept) begin
        for (int i = 0; i < 3; i++) begin
          job.pos[i] <= in_data[32*i +: 32];
          job.dir[i] <= in_data[96 + 32*i +: 32];
          job.up[i]  <= in_data[192 + 32*i +: 32];
        end
      end
      case (st)
        F_IDLE: begin
          if (accept) begin
            st <= F_MUL;
            cnt <= '0;
          end
        end
        F_MUL: begin
          if (cnt != 3'd0) begin
            if (!tag[0]) begin
              half <= prod_sh;
            end else begin
              job.right[tag[2:1]] <= sat32(72'(half - prod_sh));
            end
          end
          if (cnt == 3'd6) begin
            st <= F_PUSH;
          end
          cnt <= cnt + 3'd1;
        end
        F_PUSH: begin
          if (q_ready) begin
            if (accept) begin
              st <= F_MUL;
              cnt <= '0;
            end else begin
              st <= F_IDLE;
            end
          end
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/fcp_queue.sv -----
// two-entry queue of poses between front and back
`timescale 1ns / 1ps
module fcp_queue import fcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  job_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job = mem[rp];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/fcp_back.sv -----
// back end: corner sums, plane cross products, normalize, square root, divide, offset
`timescale 1ns / 1ps
module fcp_back import fcp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              q_valid,
  output logic              q_ready,
  input  job_t              q_job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_data,
  output logic [USER_W-1:0] out_user,
  output logic              out_last
);

  localparam int CW = 70 - FRAC_BITS;
  localparam int QW = FRAC_BITS + 2;
  localparam int NW = QW + 1;
  localparam int DCW = $clog2(QW + 1);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_CMUL  = 4'd1;
  localparam logic [3:0] B_CEMIT = 4'd2;
  localparam logic [3:0] B_EDGE  = 4'd3;
  localparam logic [3:0] B_XMUL  = 4'd4;
  localparam logic [3:0] B_ZCHK  = 4'd5;
  localparam logic [3:0] B_NORM  = 4'd6;
  localparam logic [3:0] B_SQ    = 4'd7;
  localparam logic [3:0] B_SQRT  = 4'd8;
  localparam logic [3:0] B_DIV   = 4'd9;
  localparam logic [3:0] B_DOT   = 4'd10;
  localparam logic [3:0] B_PEMIT = 4'd11;

  localparam logic signed [32:0] E_LIM = 33'sd1073741824;
  localparam logic signed [62:0] N_HI  = 63'sd1073741824;
  localparam logic signed [62:0] N_MID = 63'sd536870912;

  function automatic logic fits(input logic signed [32:0] x);
    return (x >= -E_LIM) && (x < E_LIM);
  endfunction

  function automatic logic [1:0] fit_shift(input logic signed [32:0] a,
                                           input logic signed [32:0] b,
                                           input logic signed [32:0] c);
    logic [1:0] s;
    s = 2'd3;
    for (int i = 3; i >= 0; i--) begin
      if (fits(a >>> i) && fits(b >>> i) && fits(c >>> i)) s = 2'(i);
    end
    return s;
  endfunction

  logic [3:0] st;
  logic [3:0] mi, ci;
  logic grp;
  logic [1:0] cj, pl;
  job_t job;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod, prod_sh;

  logic signed [31:0] cr [8][3];
  logic signed [CW-1:0] av [3];
  logic signed [CW-1:0] wv [3];
  logic signed [CW-1:0] hv [3];
  logic signed [CW-1:0] cs [3];
  logic signed [30:0] ev [3];
  logic signed [30:0] fv [3];
  q_t pt [3];
  logic signed [61:0] xh;
  logic signed [62:0] cv [3];
  logic [61:0] ssum;
  logic [61:0] srad;
  logic [30:0] sroot;
  logic [32:0] srem;
  logic [4:0] it;
  logic [34:0] sr2, strial;
  logic [DCW-1:0] dc;
  logic [30:0] drem [3];
  logic [QW-1:0] nl [3];
  logic [QW-1:0] qv [3];
  logic [30:0] mag [3];
  logic [31:0] dr2 [3];
  logic signed [NW-1:0] nv [3];
  logic signed [67:0] dsum;
  q_t pw;
  logic pdeg;

  logic signed [32:0] ed [3];
  logic signed [32:0] fd [3];
  q_t ptn [3];
  logic [1:0] es, fs;
  logic big, tiny, zero;

  logic [REG_W-1:0] dsel, wsel, hsel;
  logic slot_free;
  logic [2:0] kidx;

  assign q_ready = (st == B_IDLE);
  assign ci = mi - 4'd1;
  assign prod_sh = prod >>> FRAC_BITS;
  assign slot_free = !out_valid || out_ready;
  assign dsel = grp ? cfg.far_dist : cfg.near_dist;
  assign wsel = grp ? cfg.far_hw : cfg.near_hw;
  assign hsel = grp ? cfg.far_hh : cfg.near_hh;
  assign kidx = {grp, cj};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cs[i] = av[i] + (cj[1] ? wv[i] : -wv[i])
            + ((cj == 2'd0 || cj == 2'd3) ? hv[i] : -hv[i]);
      mag[i] = 31'(cv[i][62] ? -cv[i] : cv[i]);
      dr2[i] = {drem[i], nl[i][QW-1]};
      nv[i] = cv[i][62] ? -$signed(NW'({1'b0, qv[i]})) : $signed(NW'({1'b0, qv[i]}));
    end
  end

  always_comb begin
    big = 1'b0;
    tiny = 1'b1;
    zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (cv[i] >= N_HI || cv[i] <= -N_HI) big = 1'b1;
      if (!(cv[i] < N_MID && cv[i] > -N_MID)) tiny = 1'b0;
      if (cv[i] != '0) zero = 1'b0;
    end
  end

  assign sr2 = {srem, srad[61:60]};
  assign strial = {2'b00, sroot, 2'b01};

  // edge pairs and reference corner for left, right, top, bottom
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ed[i] = '0;
      fd[i] = '0;
      ptn[i] = '0;
    end
    case (pl)
      2'd0: begin
        for (int i = 0; i < 3; i++) begin
          ed[i] = 33'(cr[1][i]) - 33'(cr[0][i]);
          fd[i] = 33'(cr[4][i]) - 33'(cr[0][i]);
          ptn[i] = cr[0][i];
        end
      end
      2'd1: begin
        for (int i = 0; i < 3; i++) begin
          ed[i] = 33'(cr[7][i]) - 33'(cr[3][i]);
          fd[i] = 33'(cr[2][i]) - 33'(cr[3][i]);
          ptn[i] = cr[3][i];
        end
      end
      2'd2: begin
        for (int i = 0; i < 3; i++) begin
          ed[i] = 33'(cr[0][i]) - 33'(cr[3][i]);
          fd[i] = 33'(cr[7][i]) - 33'(cr[3][i]);
          ptn[i] = cr[3][i];
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          ed[i] = 33'(cr[2][i]) - 33'(cr[1][i]);
          fd[i] = 33'(cr[6][i]) - 33'(cr[2][i]);
          ptn[i] = cr[2][i];
        end
      end
    endcase
  end

  assign es = fit_shift(ed[0], ed[1], ed[2]);
  assign fs = fit_shift(fd[0], fd[1], fd[2]);

  always_comb begin
    ma = '0;
    mb = '0;
    case (st)
      B_CMUL: begin
        case (mi)
          4'd0, 4'd1, 4'd2: begin
            ma = {2'b00, dsel};
            mb = 33'($signed(job.dir[mi[1:0]]));
          end
          4'd3, 4'd4, 4'd5: begin
            ma = {2'b00, wsel};
            mb = 33'($signed(job.right[2'(mi - 4'd3)]));
          end
          4'd6, 4'd7, 4'd8: begin
            ma = {2'b00, hsel};
            mb = 33'($signed(job.up[2'(mi - 4'd6)]));
          end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      B_XMUL: begin
        case (mi)
          4'd0: begin ma = 33'(ev[1]); mb = 33'(fv[2]); end
          4'd1: begin ma = 33'(ev[2]); mb = 33'(fv[1]); end
          4'd2: begin ma = 33'(ev[2]); mb = 33'(fv[0]); end
          4'd3: begin ma = 33'(ev[0]); mb = 33'(fv[2]); end
          4'd4: begin ma = 33'(ev[0]); mb = 33'(fv[1]); end
          4'd5: begin ma = 33'(ev[1]); mb = 33'(fv[0]); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      B_SQ: begin
        if (mi < 4'd3) begin
          ma = 33'(cv[mi[1:0]]);
          mb = 33'(cv[mi[1:0]]);
        end
      end
      B_DOT: begin
        if (mi < 4'd3) begin
          ma = 33'(nv[mi[1:0]]);
          mb = 33'(pt[mi[1:0]]);
        end
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 66'(ma) * 66'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_IDLE;
      mi <= '0;
      grp <= 1'b0;
      cj <= '0;
      pl <= '0;
      it <= '0;
      dc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (slot_free && st != B_CEMIT && st != B_PEMIT) out_valid <= 1'b0;
      case (st)
        B_IDLE: begin
          if (q_valid) begin
            job <= q_job;
            grp <= 1'b0;
            mi <= '0;
            st <= B_CMUL;
          end
        end
        B_CMUL: begin
          case (ci)
            4'd0, 4'd1, 4'd2: av[ci[1:0]] <= CW'($signed(job.pos[ci[1:0]])) + CW'(prod_sh);
            4'd3, 4'd4, 4'd5: wv[2'(ci - 4'd3)] <= CW'(prod_sh);
            4'd6, 4'd7, 4'd8: hv[2'(ci - 4'd6)] <= CW'(prod_sh);
            default: ;
          endcase
          mi <= mi + 4'd1;
          if (mi == 4'd9) begin
            cj <= '0;
            st <= B_CEMIT;
          end
        end
        B_CEMIT: begin
          if (slot_free) begin
            for (int i = 0; i < 3; i++) cr[kidx][i] <= sat32(72'(cs[i]));
            out_valid <= 1'b1;
            out_data <= {5'b0, 32'b0, sat32(72'(cs[2])), sat32(72'(cs[1])),
                         sat32(72'(cs[0])), kidx};
            out_user <= {1'b0, KIND_CORNER};
            out_last <= 1'b0;
            cj <= cj + 2'd1;
            if (cj == 2'd3) begin
              if (!grp) begin
                grp <= 1'b1;
                mi <= '0;
                st <= B_CMUL;
              end else begin
                pl <= '0;
                st <= B_EDGE;
              end
            end
          end
        end
        B_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            ev[i] <= 31'(ed[i] >>> es);
            fv[i] <= 31'(fd[i] >>> fs);
            pt[i] <= ptn[i];
          end
          mi <= '0;
          st <= B_XMUL;
        end
        B_XMUL: begin
          if (mi != 4'd0) begin
            if (!ci[0]) begin
              xh <= 62'(prod);
            end else begin
              cv[ci[2:1]] <= 63'(xh) - 63'($signed(62'(prod)));
            end
          end
          mi <= mi + 4'd1;
          if (mi == 4'd6) st <= B_ZCHK;
        end
        B_ZCHK: begin
          if (zero) begin
            pdeg <= 1'b1;
            pw <= '0;
            st <= B_PEMIT;
          end else begin
            st <= B_NORM;
          end
        end
        B_NORM: begin
          if (big) begin
            for (int i = 0; i < 3; i++) cv[i] <= cv[i] >>> 1;
          end else if (tiny) begin
            for (int i = 0; i < 3; i++) cv[i] <= cv[i] <<< 1;
          end else begin
            mi <= '0;
            st <= B_SQ;
          end
        end
        B_SQ: begin
          if (mi == 4'd1) begin
            ssum <= 62'(prod);
          end else if (mi == 4'd2 || mi == 4'd3) begin
            ssum <= ssum + 62'(prod);
          end
          mi <= mi + 4'd1;
          if (mi == 4'd4) begin
            srad <= ssum;
            sroot <= '0;
            srem <= '0;
            it <= '0;
            st <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (sr2 >= strial) begin
            srem <= 33'(sr2 - strial);
            sroot <= {sroot[29:0], 1'b1};
          end else begin
            srem <= 33'(sr2);
            sroot <= {sroot[29:0], 1'b0};
          end
          srad <= srad << 2;
          it <= it + 5'd1;
          if (it == 5'd30) begin
            dc <= '0;
            st <= B_DIV;
          end
        end
        B_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (dc == '0) begin
              drem[i] <= mag[i] >> 2;
              nl[i] <= {mag[i][1:0], {FRAC_BITS{1'b0}}};
              qv[i] <= '0;
            end else begin
              if (dr2[i] >= {1'b0, sroot}) begin
                drem[i] <= 31'(dr2[i] - {1'b0, sroot});
                qv[i] <= {qv[i][QW-2:0], 1'b1};
              end else begin
                drem[i] <= 31'(dr2[i]);
                qv[i] <= {qv[i][QW-2:0], 1'b0};
              end
              nl[i] <= nl[i] << 1;
            end
          end
          dc <= dc + 1'b1;
          if (dc == DCW'(QW)) begin
            mi <= '0;
            st <= B_DOT;
          end
        end
        B_DOT: begin
          if (mi == 4'd1) begin
            dsum <= 68'(prod);
          end else if (mi == 4'd2 || mi == 4'd3) begin
            dsum <= dsum + 68'(prod);
          end
          mi <= mi + 4'd1;
          if (mi == 4'd4) begin
            pw <= sat32(-(72'(dsum) >>> FRAC_BITS));
            pdeg <= 1'b0;
            st <= B_PEMIT;
          end
        end
        B_PEMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_data <= {5'b0, pw,
                         pdeg ? 32'b0 : 32'(nv[2]),
                         pdeg ? 32'b0 : 32'(nv[1]),
                         pdeg ? 32'b0 : 32'(nv[0]),
                         {1'b0, pl}};
            out_user <= {pdeg, KIND_PLANE};
            out_last <= (pl == 2'd3);
            pl <= pl + 2'd1;
            st <= (pl == 2'd3) ? B_IDLE : B_EDGE;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/frustum_corners_and_planes_top.sv -----
// top level of the frustum corner and side plane generator
`timescale 1ns / 1ps
// Takes one camera pose per word on s_axis (position, direction, up, each
// three signed Q16.16 values) and returns twelve words on m_axis: the eight
// frustum corners, near then far, each top-left, bottom-left, bottom-right,
// top-right, followed by the left, right, top and bottom planes. tlast marks
// the bottom plane. Near and far distances and half extents come from the
// cfg port; the user must write them only while the block is idle, which the
// block itself does not enforce. A front stage forms the right vector and
// hands the pose to a two-entry queue; the back sequencer is paced by its
// single shared multiplier, the one-bit-per-cycle normal scaling loop, the
// 31-step square root and the FRAC_BITS+2 step divider run once for each
// nondegenerate plane. The first corner is emitted once the near centre and
// half-extent vectors are formed. With the queue and front stage, up to
// three more poses can be taken before the back end has finished the first.
// Reset clears the queue, the sequencer and the output valid flag and
// restores the register defaults. A stalled m_axis holds its word; the back
// end waits while the front keeps taking poses until the queue is full.
module frustum_corners_and_planes_top import fcp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,  // pos_x, pos_y, pos_z, dir_x..z, up_x..z
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,  // item_index, out_x, out_y, out_z, out_w
  output logic [USER_W-1:0]     m_axis_tuser,  // kind, degenerate
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]      cfg_data
);

  cfg_t cfg;
  logic fq_valid, fq_ready, bq_valid, bq_ready;
  job_t fq_job, bq_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_dist <= RST_NEAR_DIST;
      cfg.far_dist <= RST_FAR_DIST;
      cfg.near_hw <= RST_NEAR_HW;
      cfg.near_hh <= RST_NEAR_HH;
      cfg.far_hw <= RST_FAR_HW;
      cfg.far_hh <= RST_FAR_HH;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NEAR_DIST: cfg.near_dist <= cfg_data;
        REG_FAR_DIST:  cfg.far_dist <= cfg_data;
        REG_NEAR_HW:   cfg.near_hw <= cfg_data;
        REG_NEAR_HH:   cfg.near_hh <= cfg_data;
        REG_FAR_HW:    cfg.far_hw <= cfg_data;
        REG_FAR_HH:    cfg.far_hh <= cfg_data;
        default: ;
      endcase
    end
  end

  fcp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_job(fq_job)
  );

  fcp_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_job(bq_job)
  );

  fcp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(bq_valid), .q_ready(bq_ready), .q_job(bq_job),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_last(m_axis_tlast)
  );

endmodule

// ----- rtl/fcp_checker.sv -----
// port-level checks on the result stream, bound to the top level
`timescale 1ns / 1ps
module fcp_checker import fcp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata,
  input logic [USER_W-1:0] m_axis_tuser,
  input logic              m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped under stall");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word after reset");

  a_corner: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] == KIND_CORNER |->
      m_axis_tdata[130:99] == 32'd0 && !m_axis_tuser[1] && !m_axis_tlast)
    else $error("corner word with plane fields set");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser[0] == KIND_PLANE && m_axis_tdata[2:0] == 3'd3)
    else $error("tlast not on bottom plane");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tuser[0] == KIND_PLANE && m_axis_tdata[130:3] == '0)
    else $error("degenerate plane with nonzero payload");

endmodule

bind frustum_corners_and_planes_top fcp_checker u_fcp_checker (
  .clk(clk), .rst(rst),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
  .m_axis_tlast(m_axis_tlast)
);
